// File: hw/rtl/fnss_pkg.sv
// fnss_pkg: shared types and constants of the four-neighbor sum stencil
// no dependencies
`timescale 1ns / 1ps

package fnss_pkg;

    localparam int WORD_W = 32;   // matrix element width
    localparam int SUM_W  = 34;   // exact sum of four elements
    localparam int HALF_W = 33;   // sum of two elements
    localparam int CFG_W  = 6;    // written size field
    localparam int DATA_W = 32;   // apb data width
    localparam int ADDR_W = 3;    // apb byte address width

    // register index, taken from paddr[2]
    localparam logic REG_MATRIX_SIZE = 1'b0;

    // neighbor values seen at the heads of the line buffer
    typedef struct packed {
        logic [WORD_W-1:0] left;    // previous row, column to the left
        logic [WORD_W-1:0] right;   // previous row, column to the right
        logic [WORD_W-1:0] up;      // row before the previous row
    } fnss_taps_t;

    // which terms take part in a sum and how the result is marked
    typedef struct packed {
        logic use_down;
        logic use_left;
        logic use_right;
        logic use_up;
        logic last;
        logic done;
    } fnss_flags_t;

endpackage

// File: hw/rtl/four_neighbor_sum_stencil.sv
// four_neighbor_sum_stencil: top level, zero-border four-neighbor sum of a square matrix
// depends on fnss_pkg, fnss_line_buffer, fnss_sum_pipe
//
//   channel   dir   handshake                     payload
//   element   in    element_valid/element_stall   element
//   result    out   result_valid/result_stall     neighbor_sum, row_index, col_index,
//                                                 last_of_run, matrix_done
//   config    in    apb (psel/penable/pready)     matrix_size at byte address 0
//
// one word per cycle while element_stall is low; a result passes the adder stage and then the output register
// the last word of a matrix starts a flush of the last row through the
// line buffer chain, during which element_stall is high
// reset gives size 1 and position (0, 0); writing matrix_size restarts the matrix
// result_stall backs up the adder stages and then element_stall
`timescale 1ns / 1ps

module four_neighbor_sum_stencil #(
    parameter int MAX_SIZE = 32,
    parameter int IW       = $clog2(MAX_SIZE)
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              element_valid,
    output logic                              element_stall,
    input  logic signed [fnss_pkg::WORD_W-1:0] element,
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic signed [fnss_pkg::SUM_W-1:0] neighbor_sum,
    output logic [IW-1:0]                     row_index,
    output logic [IW-1:0]                     col_index,
    output logic                              last_of_run,
    output logic                              matrix_done,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [fnss_pkg::ADDR_W-1:0]       paddr,
    input  logic [fnss_pkg::DATA_W-1:0]       pwdata,
    output logic [fnss_pkg::DATA_W-1:0]       prdata,
    output logic                              pready
);
    import fnss_pkg::*;

    localparam int SW = $clog2(MAX_SIZE + 1);

    logic [SW-1:0]    size_m1_reg;
    logic [IW-1:0]    row_reg;
    logic [IW-1:0]    col_reg;
    logic             flush_reg;
    logic [IW-1:0]    fcol_reg;

    logic             cfg_write;
    logic [CFG_W-1:0] cfg_size;
    logic [SW-1:0]    size_m1_next;
    logic             accept;
    logic             flush_step;
    logic             shift;
    logic             entry_ready;
    logic             entry_valid;
    logic             col_end;
    logic             row_end;
    logic             last_elem;
    logic             flush_end;
    fnss_taps_t       taps;
    fnss_flags_t      flags;
    logic [IW-1:0]    entry_row;
    logic [IW-1:0]    entry_col;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_MATRIX_SIZE);
    assign cfg_size  = pwdata[CFG_W-1:0];

    always_comb
    begin
        if (cfg_size == '0)
        begin
            size_m1_next = '0;
        end
        else if (cfg_size > CFG_W'(MAX_SIZE))
        begin
            size_m1_next = SW'(MAX_SIZE - 1);
        end
        else
        begin
            size_m1_next = SW'(cfg_size - CFG_W'(1));
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_MATRIX_SIZE: prdata = DATA_W'(size_m1_reg) + DATA_W'(1);
            default:         prdata = '0;
        endcase
    end

    // position tracking
    assign col_end   = (SW'(col_reg) == size_m1_reg);
    assign row_end   = (SW'(row_reg) == size_m1_reg);
    assign last_elem = col_end && row_end;
    assign flush_end = (SW'(fcol_reg) == size_m1_reg);

    assign element_stall = flush_reg || !entry_ready;
    assign accept        = element_valid && !element_stall;
    assign flush_step    = flush_reg && entry_ready;
    assign shift         = accept || flush_step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_m1_reg <= '0;
            row_reg     <= '0;
            col_reg     <= '0;
            flush_reg   <= 1'b0;
            fcol_reg    <= '0;
        end
        else if (cfg_write)
        begin
            size_m1_reg <= size_m1_next;
            row_reg     <= '0;
            col_reg     <= '0;
            flush_reg   <= 1'b0;
            fcol_reg    <= '0;
        end
        else
        begin
            if (accept)
            begin
                if (col_end)
                begin
                    col_reg <= '0;
                    if (row_end)
                    begin
                        row_reg   <= '0;
                        flush_reg <= 1'b1;
                        fcol_reg  <= '0;
                    end
                    else
                    begin
                        row_reg <= row_reg + IW'(1);
                    end
                end
                else
                begin
                    col_reg <= col_reg + IW'(1);
                end
            end
            if (flush_step)
            begin
                fcol_reg <= fcol_reg + IW'(1);
                if (flush_end)
                begin
                    flush_reg <= 1'b0;
                end
            end
        end
    end

    // row 0 words only fill the line buffer
    assign entry_valid = (accept && (row_reg != '0)) || flush_step;

    always_comb
    begin
        if (flush_reg)
        begin
            flags.use_down  = 1'b0;
            flags.use_left  = (fcol_reg != '0);
            flags.use_right = !flush_end;
            flags.use_up    = (size_m1_reg != '0);
            flags.last      = flush_end;
            flags.done      = flush_end;
            entry_row       = IW'(size_m1_reg);
            entry_col       = fcol_reg;
        end
        else
        begin
            flags.use_down  = 1'b1;
            flags.use_left  = (col_reg != '0);
            flags.use_right = !col_end;
            flags.use_up    = (row_reg != '0) && (row_reg != IW'(1));
            flags.last      = !last_elem;
            flags.done      = 1'b0;
            entry_row       = row_reg - IW'(1);
            entry_col       = col_reg;
        end
    end

    fnss_line_buffer #(
        .MAX_SIZE (MAX_SIZE),
        .SW       (SW)
    ) u_line_buffer (
        .clk     (clk),
        .shift   (shift),
        .size_m1 (size_m1_reg),
        .din     (element),
        .taps    (taps)
    );

    fnss_sum_pipe #(
        .IW (IW)
    ) u_sum_pipe (
        .clk          (clk),
        .rst_n        (rst_n),
        .entry_valid  (entry_valid),
        .entry_ready  (entry_ready),
        .down         (element),
        .taps         (taps),
        .flags        (flags),
        .entry_row    (entry_row),
        .entry_col    (entry_col),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .neighbor_sum (neighbor_sum),
        .row_index    (row_index),
        .col_index    (col_index),
        .last_of_run  (last_of_run),
        .matrix_done  (matrix_done)
    );

    // the final position always closes the run of its word
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && matrix_done |-> last_of_run)
        else $error("matrix_done without last_of_run");

    // position counters stay inside the configured matrix; the flush column only while flushing
    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (SW'(col_reg) <= size_m1_reg) && (SW'(row_reg) <= size_m1_reg)
        && (!flush_reg || (SW'(fcol_reg) <= size_m1_reg)))
        else $error("position counter beyond matrix size");

    // the last word of a matrix holds off the next one while the last row drains
    a_flush_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last_elem && !cfg_write |=> element_stall)
        else $error("input taken during last row flush");

endmodule

// File: hw/rtl/fnss_cell.sv
// fnss_cell: one word of the line buffer chain
// loads its neighbor's word on a shift, or the tail word when it is the row end
// depends on fnss_pkg
`timescale 1ns / 1ps

module fnss_cell
(
    input  logic                        clk,
    input  logic                        shift,
    input  logic                        take_tail,
    input  logic [fnss_pkg::WORD_W-1:0] from_next,
    input  logic [fnss_pkg::WORD_W-1:0] from_tail,
    output logic [fnss_pkg::WORD_W-1:0] q
);
    import fnss_pkg::*;

    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] word_next;

    assign word_next = take_tail ? from_tail : from_next;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            word_reg <= word_next;
        end
    end

    assign q = word_reg;

endmodule

// File: hw/rtl/fnss_line_buffer.sv
// fnss_line_buffer: two chains of cells holding the previous row and the one before
// the new word enters the previous-row chain, whose head word moves into the older chain
// depends on fnss_pkg, fnss_cell
`timescale 1ns / 1ps

module fnss_line_buffer #(
    parameter int MAX_SIZE = 32,
    parameter int SW       = $clog2(MAX_SIZE + 1)
)
(
    input  logic                        clk,
    input  logic                        shift,
    input  logic [SW-1:0]               size_m1,
    input  logic [fnss_pkg::WORD_W-1:0] din,
    output fnss_pkg::fnss_taps_t        taps
);
    import fnss_pkg::*;

    logic [WORD_W-1:0] prev_q [MAX_SIZE];
    logic [WORD_W-1:0] old_q  [MAX_SIZE];
    logic [WORD_W-1:0] left_reg;

    for (genvar i = 0; i < MAX_SIZE; i++)
    begin : g_cells
        logic              is_tail;
        logic [WORD_W-1:0] prev_from_next;
        logic [WORD_W-1:0] old_from_next;

        assign is_tail = (size_m1 == SW'(i));

        if (i == MAX_SIZE - 1)
        begin : g_end
            assign prev_from_next = din;
            assign old_from_next  = prev_q[0];
        end
        else
        begin : g_mid
            assign prev_from_next = prev_q[i+1];
            assign old_from_next  = old_q[i+1];
        end

        fnss_cell u_prev (
            .clk       (clk),
            .shift     (shift),
            .take_tail (is_tail),
            .from_next (prev_from_next),
            .from_tail (din),
            .q         (prev_q[i])
        );

        fnss_cell u_old (
            .clk       (clk),
            .shift     (shift),
            .take_tail (is_tail),
            .from_next (old_from_next),
            .from_tail (prev_q[0]),
            .q         (old_q[i])
        );
    end

    // head word of the previous row, one column back
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            left_reg <= prev_q[0];
        end
    end

    assign taps.left  = left_reg;
    assign taps.right = prev_q[1];
    assign taps.up    = old_q[0];

endmodule

// File: hw/rtl/fnss_sum_pipe.sv
// fnss_sum_pipe: two-stage adder and output register of the stencil
// stage one adds pairs of masked terms, stage two the pair sums
// depends on fnss_pkg
`timescale 1ns / 1ps

module fnss_sum_pipe #(
    parameter int IW = 5
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        entry_valid,
    output logic                        entry_ready,
    input  logic [fnss_pkg::WORD_W-1:0] down,
    input  fnss_pkg::fnss_taps_t        taps,
    input  fnss_pkg::fnss_flags_t       flags,
    input  logic [IW-1:0]               entry_row,
    input  logic [IW-1:0]               entry_col,
    output logic                        result_valid,
    input  logic                        result_stall,
    output logic signed [fnss_pkg::SUM_W-1:0] neighbor_sum,
    output logic [IW-1:0]               row_index,
    output logic [IW-1:0]               col_index,
    output logic                        last_of_run,
    output logic                        matrix_done
);
    import fnss_pkg::*;

    logic                     s1_valid_reg;
    logic signed [HALF_W-1:0] s1_a_reg;
    logic signed [HALF_W-1:0] s1_b_reg;
    logic [IW-1:0]            s1_row_reg;
    logic [IW-1:0]            s1_col_reg;
    logic                     s1_last_reg;
    logic                     s1_done_reg;

    logic                     o_valid_reg;
    logic signed [SUM_W-1:0]  o_sum_reg;
    logic [IW-1:0]            o_row_reg;
    logic [IW-1:0]            o_col_reg;
    logic                     o_last_reg;
    logic                     o_done_reg;

    logic                     o_load;
    logic signed [HALF_W-1:0] down_t;
    logic signed [HALF_W-1:0] left_t;
    logic signed [HALF_W-1:0] right_t;
    logic signed [HALF_W-1:0] up_t;
    logic signed [HALF_W-1:0] s1_a_next;
    logic signed [HALF_W-1:0] s1_b_next;
    logic signed [SUM_W-1:0]  o_sum_next;

    assign o_load      = !o_valid_reg || !result_stall;
    assign entry_ready = !s1_valid_reg || o_load;

    always_comb
    begin
        down_t    = flags.use_down  ? HALF_W'($signed(down))       : '0;
        left_t    = flags.use_left  ? HALF_W'($signed(taps.left))  : '0;
        right_t   = flags.use_right ? HALF_W'($signed(taps.right)) : '0;
        up_t      = flags.use_up    ? HALF_W'($signed(taps.up))    : '0;
        s1_a_next = down_t + left_t;
        s1_b_next = right_t + up_t;
    end

    assign o_sum_next = SUM_W'(s1_a_reg) + SUM_W'(s1_b_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
        end
        else
        begin
            if (entry_ready)
            begin
                s1_valid_reg <= entry_valid;
            end
            if (o_load)
            begin
                o_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (entry_ready && entry_valid)
        begin
            s1_a_reg    <= s1_a_next;
            s1_b_reg    <= s1_b_next;
            s1_row_reg  <= entry_row;
            s1_col_reg  <= entry_col;
            s1_last_reg <= flags.last;
            s1_done_reg <= flags.done;
        end
        if (o_load && s1_valid_reg)
        begin
            o_sum_reg  <= o_sum_next;
            o_row_reg  <= s1_row_reg;
            o_col_reg  <= s1_col_reg;
            o_last_reg <= s1_last_reg;
            o_done_reg <= s1_done_reg;
        end
    end

    assign result_valid = o_valid_reg;
    assign neighbor_sum = o_sum_reg;
    assign row_index    = o_row_reg;
    assign col_index    = o_col_reg;
    assign last_of_run  = o_last_reg;
    assign matrix_done  = o_done_reg;

endmodule

// File: tb/tb_four_neighbor_sum_stencil.sv
// tb_four_neighbor_sum_stencil: self-checking bench for the four-neighbor sum stencil
// random element streams and size writes, sums predicted in the bench; needs fnss_pkg and the rtl
`timescale 1ns / 1ps

module tb_four_neighbor_sum_stencil;

    import fnss_pkg::*;

    localparam int MAX_SIZE       = 32;
    localparam int IW             = $clog2(MAX_SIZE);
    localparam int REG_IDX_BIT    = 2;
    localparam int SETTLE_CYCLES  = 12;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PRINT_LIMIT    = 100;
    localparam int CFG_MAX        = (1 << CFG_W) - 1;

    localparam logic [ADDR_W-1:0] SIZE_ADDR   = {REG_MATRIX_SIZE, 2'b00};
    localparam logic [ADDR_W-1:0] UNUSED_ADDR = {~REG_MATRIX_SIZE, 2'b00};

    localparam logic signed [WORD_W-1:0] ELEM_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic signed [WORD_W-1:0] ELEM_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    typedef struct packed {
        logic signed [SUM_W-1:0] nsum;
        logic [IW-1:0]           row;
        logic [IW-1:0]           col;
        logic                    run_last;
        logic                    mat_done;
    } stencil_sum_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      element_valid = 1'b0;
    logic                      element_stall;
    logic signed [WORD_W-1:0]  element = '0;
    logic                      result_valid;
    logic                      result_stall = 1'b0;
    logic signed [SUM_W-1:0]   neighbor_sum;
    logic [IW-1:0]             row_index;
    logic [IW-1:0]             col_index;
    logic                      last_of_run;
    logic                      matrix_done;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [ADDR_W-1:0]         paddr = '0;
    logic [DATA_W-1:0]         pwdata = '0;
    logic [DATA_W-1:0]         prdata;
    logic                      pready;

    // bench copy of the block state
    logic signed [WORD_W-1:0]  line_mem [2][MAX_SIZE];
    logic                      bank_sel = 1'b0;
    int                        pos_row = 0;
    int                        pos_col = 0;
    int                        cur_size = 1;

    logic signed [WORD_W-1:0]  pending_words [$];
    stencil_sum_t              expected_sums [$];
    logic                      elem_taken = 1'b0;
    int                        send_pct = 0;
    int                        stall_pct = 0;
    int                        error_count = 0;
    int                        quiet_cycles = 0;

    four_neighbor_sum_stencil #(
        .MAX_SIZE(MAX_SIZE)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .element_valid(element_valid),
        .element_stall(element_stall),
        .element(element),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .neighbor_sum(neighbor_sum),
        .row_index(row_index),
        .col_index(col_index),
        .last_of_run(last_of_run),
        .matrix_done(matrix_done),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string msg);
        if (error_count < PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    // left plus right neighbor of a column within one stored row
    function automatic logic signed [SUM_W-1:0] side_pair(input logic bank, input int col);
        logic signed [SUM_W-1:0] acc;
        acc = '0;
        if (col > 0)
            acc = acc + line_mem[bank][col-1];
        if (col + 1 < cur_size)
            acc = acc + line_mem[bank][col+1];
        return acc;
    endfunction

    function automatic stencil_sum_t make_sum(input logic signed [SUM_W-1:0] s,
                                              input int r, input int c, input logic done);
        stencil_sum_t res;
        res.nsum     = s;
        res.row      = IW'(r);
        res.col      = IW'(c);
        res.run_last = 1'b0;
        res.mat_done = done;
        return res;
    endfunction

    task automatic predict_sums(input logic signed [WORD_W-1:0] x);
        stencil_sum_t             batch [$];
        stencil_sum_t             res;
        logic signed [SUM_W-1:0]  s;
        int                       r;
        int                       j;
        logic                     last_pos;
        r = pos_row;
        j = pos_col;
        last_pos = (r == cur_size - 1) && (j == cur_size - 1);
        if (r >= 1) begin
            s = side_pair(bank_sel, j) + x;
            if (r >= 2)
                s = s + line_mem[~bank_sel][j];
            batch.push_back(make_sum(s, r - 1, j, 1'b0));
        end
        line_mem[~bank_sel][j] = x;
        if (j + 1 >= cur_size) begin
            pos_col = 0;
            bank_sel = ~bank_sel;
            pos_row = (r + 1 >= cur_size) ? 0 : r + 1;
        end
        else begin
            pos_col = j + 1;
        end
        // final word flushes the whole last row
        if (last_pos) begin
            for (int c = 0; c < cur_size; c++) begin
                s = side_pair(bank_sel, c);
                if (cur_size >= 2)
                    s = s + line_mem[~bank_sel][c];
                batch.push_back(make_sum(s, cur_size - 1, c, c == cur_size - 1));
            end
            bank_sel = 1'b0;
        end
        if (batch.size() > 0) begin
            res = batch.pop_back();
            res.run_last = 1'b1;
            batch.push_back(res);
        end
        foreach (batch[i])
            expected_sums.push_back(batch[i]);
    endtask

    // word driver
    always @(negedge clk) begin
        if (!element_valid || elem_taken) begin
            if (pending_words.size() > 0 && $urandom_range(0, 99) >= send_pct) begin
                element <= pending_words.pop_front();
                element_valid <= 1'b1;
            end
            else begin
                element_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
        result_stall <= ($urandom_range(0, 99) < stall_pct);

    // result checker, prediction and watchdog
    always @(posedge clk) begin
        stencil_sum_t want;
        logic         moved;
        moved = 1'b0;
        if (result_valid && !result_stall) begin
            moved = 1'b1;
            if (expected_sums.size() == 0) begin
                report_mismatch($sformatf("unexpected result row %0d col %0d sum %0d",
                                          row_index, col_index, neighbor_sum));
            end
            else begin
                want = expected_sums.pop_front();
                if (neighbor_sum !== want.nsum)
                    report_mismatch($sformatf("neighbor_sum %0d want %0d at (%0d,%0d)",
                                              neighbor_sum, want.nsum, want.row, want.col));
                if (row_index !== want.row)
                    report_mismatch($sformatf("row_index %0d want %0d", row_index, want.row));
                if (col_index !== want.col)
                    report_mismatch($sformatf("col_index %0d want %0d", col_index, want.col));
                if (last_of_run !== want.run_last)
                    report_mismatch($sformatf("last_of_run %b want %b at (%0d,%0d)",
                                              last_of_run, want.run_last, want.row, want.col));
                if (matrix_done !== want.mat_done)
                    report_mismatch($sformatf("matrix_done %b want %b at (%0d,%0d)",
                                              matrix_done, want.mat_done, want.row, want.col));
            end
        end
        if (element_valid && !element_stall) begin
            moved = 1'b1;
            predict_sums(element);
        end
        elem_taken <= element_valid && !element_stall;
        if (moved) begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("four_neighbor_sum_stencil regression: fail");
            $finish;
        end
        else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic wait_idle();
        @(negedge clk);
        while (pending_words.size() != 0 || element_valid || expected_sums.size() != 0)
            @(negedge clk);
        // row 0 words give no result but may still be in flight
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        int sz;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (addr[REG_IDX_BIT] == REG_MATRIX_SIZE) begin
            sz = int'(data[CFG_W-1:0]);
            if (sz < 1)
                sz = 1;
            if (sz > MAX_SIZE)
                sz = MAX_SIZE;
            cur_size = sz;
            pos_row  = 0;
            pos_col  = 0;
            bank_sel = 1'b0;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic signed [WORD_W-1:0] rand_element();
        case ($urandom_range(0, 9))
            0:       return ELEM_MAX;
            1:       return ELEM_MIN;
            2:       return WORD_W'($signed($urandom_range(0, 15)) - 8);
            default: return $urandom;
        endcase
    endfunction

    task automatic push_words(input logic signed [WORD_W-1:0] value, input int count);
        repeat (count) pending_words.push_back(value);
    endtask

    task automatic push_random(input int count);
        repeat (count) pending_words.push_back(rand_element());
    endtask

    task automatic run_phase(input int send_idle, input int recv_stall, input int quota);
        int                sent;
        int                n;
        int                nmat;
        int                tail;
        int                choice;
        logic [DATA_W-1:0] data;
        send_pct  = send_idle;
        stall_pct = recv_stall;
        sent = 0;
        while (sent < quota) begin
            wait_idle();
            choice = $urandom_range(0, 99);
            data = $urandom;
            if (choice < 5) begin
                data[CFG_W-1:0] = '0;
                n = 1;
            end
            else if (choice < 12) begin
                data[CFG_W-1:0] = CFG_W'($urandom_range(MAX_SIZE + 1, CFG_MAX));
                n = MAX_SIZE;
            end
            else begin
                n = $urandom_range(1, (choice < 30) ? 8 : 5);
                data[CFG_W-1:0] = CFG_W'(n);
            end
            if ($urandom_range(0, 19) == 0)
                apb_write(UNUSED_ADDR, $urandom);
            apb_write(SIZE_ADDR, data);
            if (n == MAX_SIZE) begin
                // saturated size: up to three rows, then cut short by the next write
                tail = $urandom_range(1, 3 * MAX_SIZE);
                push_random(tail);
                sent += tail;
            end
            else begin
                nmat = (n <= 4) ? $urandom_range(1, 3) : 1;
                push_random(nmat * n * n);
                sent += nmat * n * n;
                if (n > 1 && $urandom_range(0, 4) == 0) begin
                    tail = $urandom_range(1, n * n - 1);
                    push_random(tail);
                    sent += tail;
                end
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_pct  = 13;
        stall_pct = 80;
        // size 1 straight out of reset
        push_words(ELEM_MAX, 1);
        wait_idle();
        // zero size acts as one
        apb_write(SIZE_ADDR, '0);
        push_words(ELEM_MIN, 1);
        wait_idle();
        // write to the unused register changes nothing
        apb_write(UNUSED_ADDR, 32'h0000_0005);
        push_words(ELEM_MAX, 1);
        wait_idle();
        // upper data bits ignored, size 3; full-scale sums both ways, back to back
        apb_write(SIZE_ADDR, 32'hFFFF_FFC3);
        push_words(ELEM_MAX, 9);
        push_words(ELEM_MIN, 9);
        // partial matrix, cut short by the next size write
        push_random(4);
        wait_idle();
        // saturating size write, first row and part of the second at full width
        apb_write(SIZE_ADDR, DATA_W'(CFG_MAX));
        push_random(MAX_SIZE + 4);

        run_phase(13, 80, 40);
        run_phase(80, 13, 40);
        run_phase(0, 0, 40);

        wait_idle();
        if (error_count == 0)
            $display("four_neighbor_sum_stencil regression: pass");
        else
            $display("four_neighbor_sum_stencil regression: fail");
        $finish;
    end

endmodule
